>>> src/ura_pkg.sv
// Package for the unsigned radix to ASCII converter.
// Holds widths, register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package ura_pkg;

  // Width of the converted value and size of the digit store
  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_BITS);
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = ADDR_W + 1;

  // Radix register and its legal range
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RADIX_W-1:0] MIN_RADIX   = 5'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  // Digit tables after reset: "01234567" and "89abcdef"
  localparam logic [CFG_W-1:0] CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_OUT
  } ura_state_e;

endpackage

>>> src/unsigned_radix_to_ascii.sv
// Unsigned radix to ASCII converter, top level.
// Depends on ura_pkg for widths, register indexes and the state type.
`timescale 1ns / 1ps

// Converts one unsigned 64-bit word into its digits in a programmable
// radix (2..16) and sends them out most significant first, one character
// per output word, the final (least significant) character flagged by last_o.
// Characters come from a 16-entry table held in two 64-bit registers.
//
// Input channel (in_valid_i/in_ready_o/value_i) takes a word only while
// the block is idle. Each digit is produced by a bit-serial restoring
// divide by the radix, one quotient bit per cycle. Digits are kept in a
// 64 x 4 store and read back in reverse order; each character passes
// through a read state (S_READ) and then an output state (S_OUT).
// A stall on out_ready_i holds the current character; no digit is lost.
// Configuration writes (cfg_we_i) take effect at once and are meant only
// while idle. Reset returns the sequencer to idle, radix to ten and the
// table to "0123456789abcdef"; the digit store is not cleared.
module unsigned_radix_to_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [63:0]                   value_i,
  // output words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ura_pkg::CHAR_W-1:0]    character_o,
  output logic                          last_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [ura_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ura_pkg::CFG_W-1:0]     cfg_data_i
);

  // Configuration registers
  logic [ura_pkg::RADIX_W-1:0] radix_q;
  logic [ura_pkg::CFG_W-1:0]   chars_low_q;
  logic [ura_pkg::CFG_W-1:0]   chars_high_q;

  // Sequencer and datapath registers
  ura_pkg::ura_state_e             state_q, state_d;
  logic [ura_pkg::VALUE_BITS-1:0]  quot_q, quot_d;
  logic [ura_pkg::DIGIT_W-1:0]     rem_q, rem_d;
  logic                            nz_q, nz_d;
  logic [ura_pkg::BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [ura_pkg::COUNT_W-1:0]     count_q, count_d;
  logic [ura_pkg::ADDR_W-1:0]      ptr_q, ptr_d;

  // Digit store
  logic [ura_pkg::DIGIT_W-1:0] store_mem [ura_pkg::STORE_DEPTH];
  logic                        mem_we;
  logic [ura_pkg::DIGIT_W-1:0] rd_data_q;

  // Divide step signals
  logic [ura_pkg::RADIX_W-1:0] eff_radix;
  logic [ura_pkg::RADIX_W-1:0] trial;
  logic [ura_pkg::RADIX_W-1:0] trial_sub;
  logic                        q_bit;
  logic [ura_pkg::DIGIT_W-1:0] rem_step;
  logic [ura_pkg::CFG_W-1:0]   table_word;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q      <= ura_pkg::RADIX_RESET;
      chars_low_q  <= ura_pkg::CHARS_LOW_RESET;
      chars_high_q <= ura_pkg::CHARS_HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ura_pkg::REG_RADIX:      radix_q      <= cfg_data_i[ura_pkg::RADIX_W-1:0];
        ura_pkg::REG_CHARS_LOW:  chars_low_q  <= cfg_data_i;
        ura_pkg::REG_CHARS_HIGH: chars_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the radix to its legal range
  always_comb begin
    if (radix_q < ura_pkg::MIN_RADIX) begin
      eff_radix = ura_pkg::MIN_RADIX;
    end else if (radix_q > ura_pkg::MAX_RADIX) begin
      eff_radix = ura_pkg::MAX_RADIX;
    end else begin
      eff_radix = radix_q;
    end
  end

  // One restoring divide step: bring in the next quotient bit from the top
  always_comb begin
    trial     = {rem_q, quot_q[ura_pkg::VALUE_BITS-1]};
    q_bit     = (trial >= eff_radix);
    trial_sub = q_bit ? (trial - eff_radix) : trial;
    rem_step  = trial_sub[ura_pkg::DIGIT_W-1:0];
  end

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    nz_d        = nz_q;
    bit_cnt_d   = bit_cnt_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    mem_we      = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ura_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          quot_d    = value_i[ura_pkg::VALUE_BITS-1:0];
          rem_d     = '0;
          nz_d      = 1'b0;
          bit_cnt_d = '0;
          count_d   = '0;
          state_d   = ura_pkg::S_DIV;
        end
      end
      ura_pkg::S_DIV: begin
        quot_d    = {quot_q[ura_pkg::VALUE_BITS-2:0], q_bit};
        rem_d     = rem_step;
        nz_d      = nz_q | q_bit;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == ura_pkg::BIT_CNT_W'(ura_pkg::VALUE_BITS - 1)) begin
          // digit done: store it, then divide again or start sending
          mem_we    = 1'b1;
          count_d   = count_q + 1'b1;
          rem_d     = '0;
          nz_d      = 1'b0;
          bit_cnt_d = '0;
          if (!(nz_q | q_bit) ||
              (count_q == ura_pkg::COUNT_W'(ura_pkg::STORE_DEPTH - 1))) begin
            ptr_d   = count_q[ura_pkg::ADDR_W-1:0];
            state_d = ura_pkg::S_READ;
          end
        end
      end
      ura_pkg::S_READ: begin
        state_d = ura_pkg::S_OUT;
      end
      ura_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (ptr_q == '0) begin
            state_d = ura_pkg::S_IDLE;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            state_d = ura_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = ura_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ura_pkg::S_IDLE;
      nz_q      <= 1'b0;
      bit_cnt_q <= '0;
      count_q   <= '0;
      ptr_q     <= '0;
      quot_q    <= '0;
    end else begin
      state_q   <= state_d;
      nz_q      <= nz_d;
      bit_cnt_q <= bit_cnt_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      quot_q    <= quot_d;
    end
  end

  // Remainder shift register
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  // Digit store: write finished digit, read back at the send pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[count_q[ura_pkg::ADDR_W-1:0]] <= rem_step;
    end
    rd_data_q <= store_mem[ptr_q];
  end

  // Look up the character for the digit just read
  always_comb begin
    table_word  = rd_data_q[ura_pkg::DIGIT_W-1] ? chars_high_q : chars_low_q;
    character_o = table_word[{rd_data_q[ura_pkg::DIGIT_W-2:0], 3'b000} +: ura_pkg::CHAR_W];
    last_o      = (ptr_q == '0);
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a word is on the output");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ura_pkg::S_DIV) |-> ({1'b0, rem_q} < eff_radix))
    else $error("remainder not below radix");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ura_pkg::COUNT_W'(ura_pkg::STORE_DEPTH))
    else $error("digit count beyond store depth");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ura_pkg::S_DIV))
    else $error("accepted word did not start division");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (state_q == ura_pkg::S_IDLE))
    else $error("run did not end after last character");

endmodule
